[sv/jbt_pkg.sv]
package jbt_pkg;

  // Result field widths
  localparam int KIND_W    = 4;
  localparam int TOK_OFF_W = 16;

  // Token kinds
  localparam logic [KIND_W-1:0] K_LBRACE   = 4'd0;
  localparam logic [KIND_W-1:0] K_RBRACE   = 4'd1;
  localparam logic [KIND_W-1:0] K_LBRACKET = 4'd2;
  localparam logic [KIND_W-1:0] K_RBRACKET = 4'd3;
  localparam logic [KIND_W-1:0] K_COMMA    = 4'd4;
  localparam logic [KIND_W-1:0] K_COLON    = 4'd5;
  localparam logic [KIND_W-1:0] K_STRING   = 4'd6;
  localparam logic [KIND_W-1:0] K_NUMBER   = 4'd7;
  localparam logic [KIND_W-1:0] K_TRUE     = 4'd8;
  localparam logic [KIND_W-1:0] K_FALSE    = 4'd9;
  localparam logic [KIND_W-1:0] K_NULL     = 4'd10;
  localparam logic [KIND_W-1:0] K_ERROR    = 4'd11;
  localparam logic [KIND_W-1:0] K_END      = 4'd12;

  // One token as delivered on the result channel
  typedef struct packed {
    logic                 last;
    logic [TOK_OFF_W-1:0] end_off;
    logic [TOK_OFF_W-1:0] start_off;
    logic [KIND_W-1:0]    kind;
  } token_t;

  // Queue entry: the tokens produced by one text byte (one or two)
  typedef struct packed {
    logic   two;
    token_t tok1;
    token_t tok0;
  } entry_t;

endpackage

[sv/jbt_front.sv]
module jbt_front #(
  parameter int OFFSET_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      text_byte,
  input  logic            end_of_text,
  output logic            push,
  output jbt_pkg::entry_t entry
);
  import jbt_pkg::*;

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_STR  = 5'b00010,
    M_NUM  = 5'b00100,
    M_LIT  = 5'b01000,
    M_ERR  = 5'b10000
  } mode_t;

  // Characters of interest
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_F        = 8'h66;
  localparam logic [7:0] CH_N        = 8'h6E;
  localparam logic [7:0] CH_T        = 8'h74;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;

  // Literal tails still to skip, and literal codes
  localparam logic [2:0] SKIP_TRUE  = 3'd3;
  localparam logic [2:0] SKIP_FALSE = 3'd4;
  localparam logic [2:0] SKIP_NULL  = 3'd3;
  localparam logic [1:0] LIT_TRUE   = 2'd0;
  localparam logic [1:0] LIT_FALSE  = 2'd1;
  localparam logic [1:0] LIT_NULL   = 2'd2;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  function automatic logic [KIND_W-1:0] lit_kind(input logic [1:0] lk);
    case (lk)
      LIT_TRUE:  lit_kind = K_TRUE;
      LIT_FALSE: lit_kind = K_FALSE;
      default:   lit_kind = K_NULL;
    endcase
  endfunction

  mode_t                  mode, mode_next;
  logic [OFFSET_BITS-1:0] byte_offset, token_begin, begin_next;
  logic [2:0]             skip_remaining, skip_next, skip_dec;
  logic [1:0]             literal_kind, lk_next;

  logic [OFFSET_BITS-1:0] p, q;
  logic                   is_digit, num_part, run_idle;
  logic                   a_v, b_v, c_v;
  logic [KIND_W-1:0]      a_kind, b_kind, c_kind;
  logic [OFFSET_BITS-1:0] a_end, c_start;
  token_t                 tok_a, tok_b, tok_c;
  logic [1:0]             ntok;

  // Offsets with saturation
  assign p        = byte_offset;
  assign q        = (p == OFF_MAX) ? p : p + OFFSET_BITS'(1);
  assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
  assign num_part = is_digit || (text_byte == CH_MINUS) || (text_byte == CH_DOT);
  assign skip_dec = (skip_remaining != 3'd0) ? skip_remaining - 3'd1 : 3'd0;

  // Classify the byte against the current mode
  always_comb begin
    mode_next = mode;
    begin_next = token_begin;
    skip_next = skip_remaining;
    lk_next = literal_kind;
    a_v = 1'b0;
    a_kind = K_NUMBER;
    a_end = q;
    run_idle = 1'b0;
    b_v = 1'b0;
    b_kind = K_ERROR;

    unique case (mode)
      M_STR: begin
        if (text_byte == CH_QUOTE) begin
          a_v = 1'b1;
          a_kind = K_STRING;
          mode_next = M_IDLE;
        end
      end
      M_NUM: begin
        if (!num_part) begin
          a_v = 1'b1;
          a_kind = K_NUMBER;
          a_end = p;
          run_idle = 1'b1;
        end
      end
      M_LIT: begin
        skip_next = skip_dec;
        if (skip_dec == 3'd0) begin
          a_v = 1'b1;
          a_kind = lit_kind(literal_kind);
          mode_next = M_IDLE;
        end
      end
      M_ERR: begin
        mode_next = M_ERR;
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase

    // Byte seen between tokens
    if (run_idle) begin
      mode_next = M_IDLE;
      case (text_byte)
        CH_SPACE, CH_NL: begin
        end
        CH_LBRACE: begin
          b_v = 1'b1;
          b_kind = K_LBRACE;
        end
        CH_RBRACE: begin
          b_v = 1'b1;
          b_kind = K_RBRACE;
        end
        CH_LBRACKET: begin
          b_v = 1'b1;
          b_kind = K_LBRACKET;
        end
        CH_RBRACKET: begin
          b_v = 1'b1;
          b_kind = K_RBRACKET;
        end
        CH_COMMA: begin
          b_v = 1'b1;
          b_kind = K_COMMA;
        end
        CH_COLON: begin
          b_v = 1'b1;
          b_kind = K_COLON;
        end
        CH_QUOTE: begin
          mode_next = M_STR;
          begin_next = p;
        end
        CH_T: begin
          mode_next = M_LIT;
          begin_next = p;
          skip_next = SKIP_TRUE;
          lk_next = LIT_TRUE;
        end
        CH_F: begin
          mode_next = M_LIT;
          begin_next = p;
          skip_next = SKIP_FALSE;
          lk_next = LIT_FALSE;
        end
        CH_N: begin
          mode_next = M_LIT;
          begin_next = p;
          skip_next = SKIP_NULL;
          lk_next = LIT_NULL;
        end
        default: begin
          if (is_digit || text_byte == CH_MINUS) begin
            mode_next = M_NUM;
            begin_next = p;
          end else begin
            mode_next = M_ERR;
            b_v = 1'b1;
            b_kind = K_ERROR;
          end
        end
      endcase
    end
  end

  // Closing token on the final byte
  always_comb begin
    c_v = 1'b0;
    c_kind = K_END;
    c_start = q;
    if (end_of_text) begin
      if (mode_next == M_STR) begin
        c_v = 1'b1;
        c_kind = K_ERROR;
        c_start = begin_next;
      end else if (mode_next == M_NUM) begin
        c_v = 1'b1;
        c_kind = K_NUMBER;
        c_start = begin_next;
      end else if (mode_next == M_LIT) begin
        c_v = 1'b1;
        c_kind = lit_kind(lk_next);
        c_start = begin_next;
      end else if (!a_v && !b_v) begin
        c_v = 1'b1;
      end
    end
  end

  assign tok_a = '{last: 1'b0, end_off: TOK_OFF_W'(a_end),
                   start_off: TOK_OFF_W'(token_begin), kind: a_kind};
  assign tok_b = '{last: 1'b0, end_off: TOK_OFF_W'(q),
                   start_off: TOK_OFF_W'(p), kind: b_kind};
  assign tok_c = '{last: 1'b0, end_off: TOK_OFF_W'(q),
                   start_off: TOK_OFF_W'(c_start), kind: c_kind};

  // Pack the (at most two) tokens in order
  assign ntok = 2'(a_v) + 2'(b_v) + 2'(c_v);

  always_comb begin
    entry.tok0 = a_v ? tok_a : (b_v ? tok_b : tok_c);
    entry.tok1 = (a_v && b_v) ? tok_b : tok_c;
    entry.two = (ntok == 2'd2);
    if (entry.two) begin
      entry.tok1.last = end_of_text;
    end else begin
      entry.tok0.last = end_of_text;
    end
  end

  assign push = accept && (ntok != 2'd0);

  // Lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      byte_offset <= '0;
      token_begin <= '0;
      skip_remaining <= '0;
      literal_kind <= '0;
    end else if (accept) begin
      if (end_of_text) begin
        mode <= M_IDLE;
        byte_offset <= '0;
        token_begin <= '0;
        skip_remaining <= '0;
        literal_kind <= '0;
      end else begin
        mode <= mode_next;
        byte_offset <= q;
        token_begin <= begin_next;
        skip_remaining <= skip_next;
        literal_kind <= lk_next;
      end
    end
  end

endmodule

[sv/jbt_queue.sv]
module jbt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jbt_pkg::entry_t push_entry,
  output logic            full,
  output logic            not_empty,
  input  logic            pop,
  output jbt_pkg::entry_t head
);
  import jbt_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full      = (count == (PTR_W + 1)'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (PTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PTR_W + 1)'(1);
      end
    end
  end

endmodule

[sv/jbt_back.sv]
module jbt_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  jbt_pkg::entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output jbt_pkg::token_t out_tok
);
  import jbt_pkg::*;

  logic second;
  logic load;

  // Output register free or being drained this cycle
  assign load = !out_valid || out_ready;
  assign pop  = load && head_valid && (second || !head.two);

  // Payload: one token per cycle from the head entry while the output can load
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_tok <= second ? head.tok1 : head.tok0;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        second <= head.two && !second;
      end
    end
  end

endmodule

[sv/json_byte_tokenizer_core.sv]
// JSON byte tokenizer.
// Slave stream: one text byte per transfer on s_tdata, s_tlast set on the
// final byte of a document. Master stream: one token per transfer, with
// kind and start/end byte offsets in m_tdata and m_tlast on the document's
// final token. A byte yields zero, one or two tokens.
// A byte is taken every cycle while the four-entry token queue between the
// lexer front end and the output stage has room; the output stage sends
// one token per cycle while the receiver is ready, so a run of bytes that
// give two tokens each can fill the queue. The first token of a byte passes
// through the queue and then the output register to the master side.
// When the receiver stalls, the output register holds its token and the
// queue absorbs up to four more bytes' tokens before s_tready drops.
// Synchronous reset empties the queue and the output register and returns
// the lexer to idle at offset 0; the final byte of a document does the
// same to the lexer, so the next byte starts a new document.
// Offsets count in OFFSET_BITS bits, saturate at the top and leave the
// block as their low 16 bits.
module json_byte_tokenizer_core #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [3:0] token_kind, [19:4] token_start,
                                 // [35:20] token_end, [39:36] zero
  output logic        m_tlast    // last_result
);
  import jbt_pkg::*;

  logic   accept, push, q_full, q_not_empty, pop;
  entry_t push_entry, head;
  token_t out_tok;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  jbt_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .text_byte  (s_tdata),
    .end_of_text(s_tlast),
    .push       (push),
    .entry      (push_entry)
  );

  jbt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (pop),
    .head      (head)
  );

  jbt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(q_not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_tok   (out_tok)
  );

  // Result packing
  assign m_tdata = {4'b0000, out_tok.end_off, out_tok.start_off, out_tok.kind};
  assign m_tlast = out_tok.last;

endmodule

[verif/json_byte_tokenizer_core_test.sv]
module json_byte_tokenizer_core_test;
  import jbt_pkg::*;

  localparam int CYCLE_LIMIT = 60000;
  localparam int DRAIN_CYCLES = 8;

  // Lexer states of the predictor
  typedef enum logic [4:0] {
    LX_IDLE    = 5'b00001,
    LX_STRING  = 5'b00010,
    LX_NUMBER  = 5'b00100,
    LX_LITERAL = 5'b01000,
    LX_ERROR   = 5'b10000
  } lex_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] text_byte
  logic        s_tlast = 1'b0;   // end_of_text
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;          // [3:0] token_kind, [19:4] token_start,
                                 // [35:20] token_end, [39:36] zero
  logic        m_tlast;          // last_result

  json_byte_tokenizer_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  // Predictor state
  lex_mode_t         lx_mode = LX_IDLE;
  logic [15:0]       lx_pos = 16'd0;
  logic [15:0]       lx_begin = 16'd0;
  int                lx_skip = 0;
  logic [KIND_W-1:0] lx_lit = K_TRUE;

  token_t byte_tokens[$];
  token_t pending_tokens[$];
  logic [7:0] doc_bytes[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int sent_bytes = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  function automatic logic [15:0] sat_next(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic bit is_number_char(input logic [7:0] b);
    return b == "-" || b == "." || (b >= "0" && b <= "9");
  endfunction

  function void emit_token(input logic [KIND_W-1:0] k, input logic [15:0] s,
                           input logic [15:0] e);
    token_t t;
    t.last = 1'b0;
    t.end_off = e;
    t.start_off = s;
    t.kind = k;
    byte_tokens.insert(byte_tokens.size(), t);
  endfunction

  function void add_doc_byte(input logic [7:0] b);
    doc_bytes.insert(doc_bytes.size(), b);
  endfunction

  // A byte seen between tokens
  function void lex_between(input logic [7:0] b, input logic [15:0] p,
                            input logic [15:0] q);
    lx_mode = LX_IDLE;
    case (b)
      " ", "\n": ;
      "{": emit_token(K_LBRACE, p, q);
      "}": emit_token(K_RBRACE, p, q);
      "[": emit_token(K_LBRACKET, p, q);
      "]": emit_token(K_RBRACKET, p, q);
      ",": emit_token(K_COMMA, p, q);
      ":": emit_token(K_COLON, p, q);
      "\"": begin
        lx_mode = LX_STRING;
        lx_begin = p;
      end
      "t": begin
        lx_mode = LX_LITERAL; lx_begin = p; lx_skip = 3; lx_lit = K_TRUE;
      end
      "f": begin
        lx_mode = LX_LITERAL; lx_begin = p; lx_skip = 4; lx_lit = K_FALSE;
      end
      "n": begin
        lx_mode = LX_LITERAL; lx_begin = p; lx_skip = 3; lx_lit = K_NULL;
      end
      default: begin
        if (b == "-" || (b >= "0" && b <= "9")) begin
          lx_mode = LX_NUMBER;
          lx_begin = p;
        end else begin
          lx_mode = LX_ERROR;
          emit_token(K_ERROR, p, q);
        end
      end
    endcase
  endfunction

  // Tokens caused by one accepted byte, appended to the pending list
  function void lex_text_byte(input logic [7:0] b, input logic fin);
    logic [15:0] p;
    logic [15:0] q;
    byte_tokens.delete();
    p = lx_pos;
    q = sat_next(p);
    case (lx_mode)
      LX_STRING: begin
        if (b == "\"") begin
          emit_token(K_STRING, lx_begin, q);
          lx_mode = LX_IDLE;
        end
      end
      LX_NUMBER: begin
        if (!is_number_char(b)) begin
          emit_token(K_NUMBER, lx_begin, p);
          lex_between(b, p, q);
        end
      end
      LX_LITERAL: begin
        if (lx_skip > 0) lx_skip--;
        if (lx_skip == 0) begin
          emit_token(lx_lit, lx_begin, q);
          lx_mode = LX_IDLE;
        end
      end
      LX_ERROR: ;
      default: lex_between(b, p, q);
    endcase
    lx_pos = q;
    // Final byte closes whatever is open and resets the lexer
    if (fin) begin
      case (lx_mode)
        LX_STRING:  emit_token(K_ERROR, lx_begin, q);
        LX_NUMBER:  emit_token(K_NUMBER, lx_begin, q);
        LX_LITERAL: emit_token(lx_lit, lx_begin, q);
        default: ;
      endcase
      if (byte_tokens.size() == 0) emit_token(K_END, q, q);
      byte_tokens[byte_tokens.size() - 1].last = 1'b1;
      lx_mode = LX_IDLE;
      lx_pos = 16'd0;
      lx_begin = 16'd0;
      lx_skip = 0;
      lx_lit = K_TRUE;
    end
    foreach (byte_tokens[i]) pending_tokens.insert(pending_tokens.size(), byte_tokens[i]);
  endfunction

  // Offer one byte, wait for its transfer, then predict its tokens
  task send_text_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= fin;
    do @(posedge clk); while (!s_tready);
    sent_bytes++;
    lex_text_byte(b, fin);
  endtask

  task send_text(input string s, input bit fin_on_last);
    for (int i = 0; i < s.len(); i++)
      send_text_byte(s[i], fin_on_last && (i == s.len() - 1));
  endtask

  // Stop offering and wait for every outstanding token
  task wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_tokens.size() != 0);
  endtask

  task set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Receiver side: stalls, hold-off and result checking
  always @(posedge clk) begin : rx_side
    token_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_tokens.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected token: kind %0d start %0d end %0d last %0b",
                   m_tdata[3:0], m_tdata[19:4], m_tdata[35:20], m_tlast);
      end else begin
        want = pending_tokens.pop_front();
        if (m_tdata[3:0] !== want.kind || m_tdata[19:4] !== want.start_off ||
            m_tdata[35:20] !== want.end_off || m_tlast !== want.last ||
            m_tdata[39:36] !== 4'd0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("token mismatch: expected kind %0d start %0d end %0d last %0b pad 0,",
                     want.kind, want.start_off, want.end_off, want.last,
                     " got kind %0d start %0d end %0d last %0b pad %0h",
                     m_tdata[3:0], m_tdata[19:4], m_tdata[35:20], m_tlast,
                     m_tdata[39:36]);
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Every punctuation token, whitespace, and the end token
  task test_punctuation();
    send_text("{}[],: \n", 1'b1);
  endtask

  // Strings and numbers; a closing bracket that also closes a number
  task test_strings_numbers();
    send_text("\"x\"-1.2]", 1'b1);
  endtask

  // All three literals, the last one ending on the final byte
  task test_literals();
    send_text("t123f1234n12l", 1'b1);
  endtask

  // Final byte inside an open string, number, literal and after an error
  task test_document_end();
    send_text("\"ab", 1'b1);
    send_text("7", 1'b1);
    send_text("tr", 1'b1);
    send_text(".x1", 1'b1);
  endtask

  // Lowest and highest byte values
  task test_byte_extremes();
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hFF, 1'b1);
    send_text_byte(8'hFF, 1'b1);
  endtask

  // Long receiver hold-off while the sender keeps offering
  task test_backpressure();
    set_idling(0, 0);
    wait_drained();
    hold_left = 300;
    for (int i = 0; i < 40; i++) send_text_byte(",", 1'b0);
    for (int i = 0; i < 20; i++) send_text("1:", 1'b0);
    send_text("]", 1'b1);
    wait_drained();
    hold_left = 150;
    for (int i = 0; i < 30; i++) send_text("-:", 1'b0);
    send_text("2", 1'b1);
    wait_drained();
  endtask

  // Append one random token-shaped piece of text
  task add_piece();
    int sel;
    int n;
    string punct;
    punct = "{}[],:";
    sel = $urandom_range(0, 15);
    if (sel < 4) begin
      add_doc_byte(punct[$urandom_range(0, 5)]);
    end else if (sel < 5) begin
      add_doc_byte($urandom_range(0, 1) ? 8'h20 : 8'h0A);
    end else if (sel < 8) begin
      add_doc_byte("\"");
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == "\"") c = 8'hA2;
        add_doc_byte(c);
      end
      add_doc_byte("\"");
    end else if (sel < 11) begin
      add_doc_byte(($urandom_range(0, 3) == 0) ? "-" : 8'(48 + $urandom_range(0, 9)));
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 5))
          0: add_doc_byte("-");
          1: add_doc_byte(".");
          default: add_doc_byte(8'(48 + $urandom_range(0, 9)));
        endcase
      end
    end else if (sel < 14) begin
      case ($urandom_range(0, 2))
        0: begin add_doc_byte("t"); n = 3; end
        1: begin add_doc_byte("f"); n = 4; end
        default: begin add_doc_byte("n"); n = 3; end
      endcase
      for (int i = 0; i < n; i++) add_doc_byte(8'($urandom_range(0, 255)));
    end else if (sel < 15) begin
      add_doc_byte(punct[$urandom_range(0, 5)]);
    end else begin
      add_doc_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Random documents until about n bytes have been sent
  task test_random_text(input int n_bytes);
    int target;
    int pieces;
    int cut;
    target = sent_bytes + n_bytes;
    while (sent_bytes < target) begin
      doc_bytes.delete();
      pieces = $urandom_range(1, 12);
      for (int i = 0; i < pieces; i++) add_piece();
      // Some documents are cut short, possibly ending inside a token
      if ($urandom_range(0, 4) == 0) begin
        cut = $urandom_range(1, doc_bytes.size());
        while (doc_bytes.size() > cut) void'(doc_bytes.pop_back());
      end
      foreach (doc_bytes[i])
        send_text_byte(doc_bytes[i], i == doc_bytes.size() - 1);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(20, 60);
    test_punctuation();
    test_strings_numbers();
    test_literals();
    test_document_end();
    test_byte_extremes();
    test_random_text(400);

    set_idling(60, 20);
    test_random_text(400);

    test_backpressure();

    set_idling(0, 0);
    test_random_text(400);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_tokens.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
